/* rtl/lgs_pkg.sv */
// Shared types, constants and the B3/S23 rule for the life generation stencil unit.
package lgs_pkg;

    localparam int unsigned CFG_W       = 11;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned MIN_SIDE    = 3;
    localparam int unsigned DEFAULT_SIDE = 1024;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [2:0] t_column;

    typedef struct packed {
        logic x;
        logic row_ge1;
        logic row_ge2;
        logic col_first;
        logic last;
    } t_item_ctl;

    function automatic logic life_rule(t_column a, t_column b, t_column c);
        logic [3:0] count;
        count = 4'(a[0]) + 4'(a[1]) + 4'(a[2]) + 4'(b[0]) + 4'(b[2])
              + 4'(c[0]) + 4'(c[1]) + 4'(c[2]);
        if (count == 4'd3) begin
            return 1'b1;
        end else if (count == 4'd2) begin
            return b[1];
        end
        return 1'b0;
    endfunction

endpackage

/* rtl/lgs_if.sv */
// Valid/ready channel interfaces for input cells and next-generation results.
interface lgs_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic cell_alive;

    modport source (output valid, output opcode, output cell_alive, input ready);
    modport sink (input valid, input opcode, input cell_alive, output ready);
endinterface

interface lgs_out_if;
    logic                     valid;
    logic                     ready;
    logic                     next_alive;
    logic [lgs_pkg::POS_W-1:0] cell_row;
    logic [lgs_pkg::POS_W-1:0] cell_col;
    logic                     board_done;

    modport source (output valid, output next_alive, output cell_row, output cell_col,
                    output board_done, input ready);
    modport sink (input valid, input next_alive, input cell_row, input cell_col,
                  input board_done, output ready);
endinterface

/* rtl/lgs_line_mem.sv */
// Two-line buffer memory holding the upper and middle row bits for each column.
module lgs_line_mem #(
    parameter int unsigned MAX_SIDE = 1024,
    parameter int unsigned CW       = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [CW-1:0] i_rd_addr,
    output logic [1:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [CW-1:0] i_wr_addr,
    input  logic [1:0]    i_wr_data
);

    logic [1:0] r_mem [MAX_SIDE];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/lgs_scan.sv */
// Board side register and raster position counters for incoming cells.
module lgs_scan #(
    parameter int unsigned MAX_SIDE = 1024,
    parameter int unsigned SW       = 11,
    parameter int unsigned CW       = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lgs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_accept,
    input  logic                      i_opcode,
    input  logic                      i_cell_alive,
    output logic [SW-1:0]             o_side,
    output lgs_pkg::t_item_ctl        o_ctl,
    output logic [SW-1:0]             o_row,
    output logic [CW-1:0]             o_col
);

    localparam int unsigned RESET_SIDE =
        (lgs_pkg::DEFAULT_SIDE > MAX_SIDE) ? MAX_SIDE : lgs_pkg::DEFAULT_SIDE;

    logic [SW-1:0] r_side;
    logic [SW-1:0] r_row;
    logic [SW-1:0] n_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [SW-1:0] n_side;
    logic          on_board;

    always_comb begin
        if (32'(i_cfg_wdata) < lgs_pkg::MIN_SIDE) begin
            n_side = SW'(lgs_pkg::MIN_SIDE);
        end else if (32'(i_cfg_wdata) > MAX_SIDE) begin
            n_side = SW'(MAX_SIDE);
        end else begin
            n_side = SW'(i_cfg_wdata);
        end
    end

    assign on_board        = r_row < r_side;
    assign o_ctl.x         = on_board && (i_opcode == lgs_pkg::OP_CELL) && i_cell_alive;
    assign o_ctl.row_ge1   = r_row >= SW'(1);
    assign o_ctl.row_ge2   = r_row >= SW'(2);
    assign o_ctl.col_first = r_col == '0;
    assign o_ctl.last      = r_row == (r_side + SW'(1));

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (o_ctl.last) begin
            n_row = '0;
            n_col = '0;
        end else if (r_col == CW'(r_side - SW'(1))) begin
            n_row = r_row + SW'(1);
            n_col = '0;
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SW'(RESET_SIDE);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_side <= n_side;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_side = r_side;
    assign o_row  = r_row;
    assign o_col  = r_col;

endmodule

/* rtl/lgs_window.sv */
// Line-buffer write-back, 3x3 window and result register of the stencil pipeline.
module lgs_window #(
    parameter int unsigned SW = 11,
    parameter int unsigned CW = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [SW-1:0]                     i_side,
    input  logic                              i_valid,
    input  lgs_pkg::t_item_ctl                i_ctl,
    input  logic [SW-1:0]                     i_row,
    input  logic [CW-1:0]                     i_col,
    output logic                              o_take,
    input  logic [1:0]                        i_rd_data,
    output logic                              o_wr_en,
    output logic [CW-1:0]                     o_wr_addr,
    output logic [1:0]                        o_wr_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_next_alive,
    output logic [lgs_pkg::POS_W-1:0]         o_cell_row,
    output logic [lgs_pkg::POS_W-1:0]         o_cell_col,
    output logic                              o_board_done
);

    logic                      r_v1;
    lgs_pkg::t_item_ctl        r_ctl;
    logic [SW-1:0]             r_row1;
    logic [CW-1:0]             r_col1;
    lgs_pkg::t_column          r_win [3];
    logic                      r_ov;
    logic                      r_alive;
    logic [lgs_pkg::POS_W-1:0] r_orow;
    logic [lgs_pkg::POS_W-1:0] r_ocol;
    logic                      r_done;

    logic                      free;
    logic                      move;
    lgs_pkg::t_column          col;
    logic                      emit;
    logic                      value;
    logic [lgs_pkg::POS_W-1:0] n_orow;
    logic [lgs_pkg::POS_W-1:0] n_ocol;

    assign free   = !r_ov || i_out_ready;
    assign move   = r_v1 && free;
    assign o_take = !r_v1 || move;

    assign col = {r_ctl.x, r_ctl.row_ge1 & i_rd_data[0], r_ctl.row_ge2 & i_rd_data[1]};

    assign o_wr_en   = move;
    assign o_wr_addr = r_col1;
    assign o_wr_data = {i_rd_data[0], r_ctl.x};

    always_comb begin
        if (r_ctl.col_first) begin
            emit   = r_ctl.row_ge2;
            value  = lgs_pkg::life_rule(r_win[1], r_win[2], '0);
            n_orow = lgs_pkg::POS_W'(r_row1 - SW'(2));
            n_ocol = lgs_pkg::POS_W'(i_side - SW'(1));
        end else begin
            emit   = r_ctl.row_ge1;
            value  = lgs_pkg::life_rule(r_win[1], r_win[2], col);
            n_orow = lgs_pkg::POS_W'(r_row1 - SW'(1));
            n_ocol = lgs_pkg::POS_W'(r_col1 - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_take) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_ctl  <= i_ctl;
            r_row1 <= i_row;
            r_col1 <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (move) begin
            if (r_ctl.col_first) begin
                r_win[0] <= '0;
                r_win[1] <= '0;
            end else begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
            end
            r_win[2] <= col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (free) begin
            r_ov <= move && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_alive <= value;
            r_orow  <= n_orow;
            r_ocol  <= n_ocol;
            r_done  <= r_ctl.last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_next_alive = r_alive;
    assign o_cell_row   = r_orow;
    assign o_cell_col   = r_ocol;
    assign o_board_done = r_done;

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !free |=> r_v1 && $stable(r_col1) && $stable(r_row1))
        else $error("stalled stage lost its item");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !move |-> !r_v1 || !o_take)
        else $error("new beat taken over a held item");

    a_edge_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && emit && r_ctl.col_first |=> r_ocol == lgs_pkg::POS_W'(i_side - SW'(1)))
        else $error("row-end result not on the last column");

    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && emit && r_ctl.last |=> r_done && r_orow == lgs_pkg::POS_W'(i_side - SW'(1)))
        else $error("board end not on the last row");

endmodule

/* rtl/life_generation_stencil_unit.sv */
// Top level of the life generation stencil unit: one B3/S23 generation over a raster stream.
//
//  channel   direction  payload                                   handshake
//  i_in      in         opcode, cell_alive                        valid / ready
//  o_out     out        next_alive, cell_row, cell_col, board_done valid / ready
//  cfg       in         i_cfg_wdata (board side)                  i_cfg_we
//
// One beat is taken every cycle while the output is not stalled; the beat that completes a
// result passes the window stage register and then the output register. The line buffer
// memory is read at acceptance and written back when the beat leaves the window stage.
// Reset and a side write clear the position counters and the window; the lines need no clearing.
// A stalled output register holds the pipeline stage behind it, so i_in.ready falls with it.
module life_generation_stencil_unit #(
    parameter int unsigned MAX_SIDE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lgs_pkg::CFG_W-1:0] i_cfg_wdata,
    lgs_in_if.sink                    i_in,
    lgs_out_if.source                 o_out
);

    localparam int unsigned SW = $clog2(MAX_SIDE + 2);
    localparam int unsigned CW = $clog2(MAX_SIDE);

    logic               take;
    logic               accept;
    logic [SW-1:0]      side;
    lgs_pkg::t_item_ctl ctl;
    logic [SW-1:0]      row;
    logic [CW-1:0]      col;
    logic [1:0]         rd_data;
    logic               wr_en;
    logic [CW-1:0]      wr_addr;
    logic [1:0]         wr_data;

    assign accept     = i_in.valid && take;
    assign i_in.ready = take;

    lgs_scan #(
        .MAX_SIDE (MAX_SIDE),
        .SW       (SW),
        .CW       (CW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_opcode     (i_in.opcode),
        .i_cell_alive (i_in.cell_alive),
        .o_side       (side),
        .o_ctl        (ctl),
        .o_row        (row),
        .o_col        (col)
    );

    lgs_line_mem #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    lgs_window #(
        .SW (SW),
        .CW (CW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_side       (side),
        .i_valid      (i_in.valid),
        .i_ctl        (ctl),
        .i_row        (row),
        .i_col        (col),
        .o_take       (take),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_next_alive (o_out.next_alive),
        .o_cell_row   (o_out.cell_row),
        .o_cell_col   (o_out.cell_col),
        .o_board_done (o_out.board_done)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the life generation stencil unit, with its own next-generation predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned MAX_SIDE      = 1024;
    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LIMIT_CYCLES  = 5000000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned DIRECTED_ROWS = 26;
    localparam logic [lgs_pkg::CFG_W-1:0] SIDE_REG_MAX = '1;

    typedef struct packed {
        logic                      next_alive;
        logic [lgs_pkg::POS_W-1:0] row;
        logic [lgs_pkg::POS_W-1:0] col;
        logic                      board_done;
    } t_cell_result;

    typedef struct packed {
        logic         opcode;
        logic         cell_alive;
        logic         typed;
        t_cell_result want;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [lgs_pkg::CFG_W-1:0] cfg_wdata;
    bit                        tx_idle_on;
    bit                        rx_idle_on;
    bit                        hold_request;

    lgs_in_if  cell_if ();
    lgs_out_if next_if ();

    life_generation_stencil_unit #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (cell_if),
        .o_out      (next_if)
    );

    // Predictor state for the board being streamed.
    logic [lgs_pkg::CFG_W-1:0] side_reg;
    bit                        upper_row_bits [MAX_SIDE];
    bit                        middle_row_bits[MAX_SIDE];
    lgs_pkg::t_column          win_cols[3];
    logic [20:0]               cell_position;

    t_cell_result next_gen_q[$];
    int unsigned  failures;
    int unsigned  item_count;
    t_stim_row    directed_rows[DIRECTED_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned active_side();
        if (side_reg < lgs_pkg::MIN_SIDE) begin
            return lgs_pkg::MIN_SIDE;
        end else if (side_reg > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(side_reg);
    endfunction

    function automatic logic life_next(lgs_pkg::t_column left, lgs_pkg::t_column centre,
                                       lgs_pkg::t_column right);
        int unsigned neighbours;
        neighbours = $countones(left) + $countones(right) + int'(centre[0]) + int'(centre[2]);
        if (neighbours == 3) begin
            return 1'b1;
        end else if (neighbours == 2) begin
            return centre[1];
        end
        return 1'b0;
    endfunction

    function automatic void restart_board();
        win_cols      = '{default: '0};
        cell_position = '0;
    endfunction

    function automatic bit step_board(input logic op, input logic alive,
                                      output t_cell_result res);
        int unsigned      s;
        int unsigned      cells;
        int unsigned      p;
        int unsigned      ir;
        int unsigned      ic;
        logic             x;
        logic             up;
        logic             mid;
        lgs_pkg::t_column column;
        bit               emit;
        s     = active_side();
        cells = s * s;
        p     = int'(cell_position);
        ir    = p / s;
        ic    = p % s;
        x     = (op == lgs_pkg::OP_CELL && p < cells) ? alive : 1'b0;
        up    = (ir >= 2) ? upper_row_bits[ic] : 1'b0;
        mid   = (ir >= 1) ? middle_row_bits[ic] : 1'b0;
        column = {x, mid, up};
        upper_row_bits[ic]  = middle_row_bits[ic];
        middle_row_bits[ic] = x;
        emit = 1'b0;
        res  = '0;
        if (ic == 0) begin
            if (ir >= 2) begin
                res.next_alive = life_next(win_cols[1], win_cols[2], '0);
                res.row        = lgs_pkg::POS_W'(ir - 2);
                res.col        = lgs_pkg::POS_W'(s - 1);
                emit           = 1'b1;
            end
            win_cols[0] = '0;
            win_cols[1] = '0;
            win_cols[2] = column;
        end else begin
            win_cols[0] = win_cols[1];
            win_cols[1] = win_cols[2];
            win_cols[2] = column;
            if (ir >= 1) begin
                res.next_alive = life_next(win_cols[0], win_cols[1], win_cols[2]);
                res.row        = lgs_pkg::POS_W'(ir - 1);
                res.col        = lgs_pkg::POS_W'(ic - 1);
                emit           = 1'b1;
            end
        end
        cell_position = cell_position + 1'b1;
        if (emit) begin
            res.board_done = (p == cells + s);
            if (res.board_done) begin
                restart_board();
            end
        end
        return emit;
    endfunction

    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 48);
    endfunction

    function automatic t_stim_row plain_row(logic op, logic alive);
        return '{opcode: op, cell_alive: alive, typed: 1'b0, want: '0};
    endfunction

    function automatic t_stim_row typed_row(logic op, logic alive, logic na, int unsigned r,
                                            int unsigned c, logic done);
        return '{opcode: op, cell_alive: alive, typed: 1'b1,
                 want: '{next_alive: na, row: lgs_pkg::POS_W'(r), col: lgs_pkg::POS_W'(c),
                         board_done: done}};
    endfunction

    task automatic feed(input logic op, input logic alive, input bit typed,
                        input t_cell_result typed_res);
        t_cell_result res;
        int unsigned  gap;
        if (tx_idle_on && $urandom_range(0, 99) < 25) begin
            gap = idle_length();
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.opcode     <= op;
        cell_if.cell_alive <= alive;
        do @(posedge i_clk); while (!cell_if.ready);
        if (step_board(op, alive, res)) begin
            next_gen_q.push_back(typed ? typed_res : res);
        end
        item_count++;
    endtask

    task automatic wait_idle();
        cell_if.valid <= 1'b0;
        while (next_gen_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [lgs_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        side_reg  = value;
        restart_board();
    endtask

    task automatic log_mismatch(input string what);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endtask

    // Result side: ready with random stalls and one long hold-off.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_taken;
        stall_left    = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        next_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                next_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                next_if.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
                stall_left = idle_length() - 1;
                next_if.ready <= 1'b0;
            end else begin
                next_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell_result seen;
        t_cell_result want;
        if (i_rst_n && next_if.valid && next_if.ready) begin
            seen = '{next_alive: next_if.next_alive, row: next_if.cell_row,
                     col: next_if.cell_col, board_done: next_if.board_done};
            if (next_gen_q.size() == 0) begin
                log_mismatch($sformatf("Unexpected beat: alive %0d row %0d col %0d done %0d",
                                       seen.next_alive, seen.row, seen.col, seen.board_done));
            end else begin
                want = next_gen_q.pop_front();
                if (seen.next_alive !== want.next_alive || seen.row !== want.row
                        || seen.col !== want.col || seen.board_done !== want.board_done) begin
                    log_mismatch($sformatf(
                        "Mismatch: expected alive %0d row %0d col %0d done %0d, got %0d %0d %0d %0d",
                        want.next_alive, want.row, want.col, want.board_done,
                        seen.next_alive, seen.row, seen.col, seen.board_done));
                end
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned s;
        int unsigned cells;
        int unsigned length;
        int unsigned density;
        int unsigned kind;
        int unsigned boards;
        int unsigned pick;
        logic [lgs_pkg::CFG_W-1:0] value;
        logic op;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        cell_if.valid      <= 1'b0;
        cell_if.opcode     <= lgs_pkg::OP_CELL;
        cell_if.cell_alive <= 1'b0;
        rx_idle_on         <= 1'b1;
        hold_request       <= 1'b0;
        tx_idle_on          = 1'b1;
        failures            = 0;
        item_count          = 0;
        side_reg            = lgs_pkg::CFG_W'(lgs_pkg::DEFAULT_SIDE);
        restart_board();

        // A blinker with its next generation typed in, then a full board with a flush
        // inside it, a cell after it, and flush beats that carry a live bit.
        directed_rows = '{
            plain_row(lgs_pkg::OP_CELL, 1'b0), plain_row(lgs_pkg::OP_CELL, 1'b0),
            plain_row(lgs_pkg::OP_CELL, 1'b0), plain_row(lgs_pkg::OP_CELL, 1'b1),
            typed_row(lgs_pkg::OP_CELL, 1'b1, 1'b0, 0, 0, 1'b0),
            typed_row(lgs_pkg::OP_CELL, 1'b1, 1'b1, 0, 1, 1'b0),
            typed_row(lgs_pkg::OP_CELL, 1'b0, 1'b0, 0, 2, 1'b0),
            typed_row(lgs_pkg::OP_CELL, 1'b0, 1'b0, 1, 0, 1'b0),
            typed_row(lgs_pkg::OP_CELL, 1'b0, 1'b1, 1, 1, 1'b0),
            typed_row(lgs_pkg::OP_FLUSH, 1'b0, 1'b0, 1, 2, 1'b0),
            typed_row(lgs_pkg::OP_FLUSH, 1'b0, 1'b0, 2, 0, 1'b0),
            typed_row(lgs_pkg::OP_FLUSH, 1'b0, 1'b1, 2, 1, 1'b0),
            typed_row(lgs_pkg::OP_FLUSH, 1'b0, 1'b0, 2, 2, 1'b1),
            plain_row(lgs_pkg::OP_CELL, 1'b1), plain_row(lgs_pkg::OP_CELL, 1'b1),
            plain_row(lgs_pkg::OP_CELL, 1'b1), plain_row(lgs_pkg::OP_CELL, 1'b1),
            plain_row(lgs_pkg::OP_FLUSH, 1'b1), plain_row(lgs_pkg::OP_CELL, 1'b1),
            plain_row(lgs_pkg::OP_CELL, 1'b1), plain_row(lgs_pkg::OP_CELL, 1'b1),
            plain_row(lgs_pkg::OP_CELL, 1'b1), plain_row(lgs_pkg::OP_CELL, 1'b1),
            plain_row(lgs_pkg::OP_FLUSH, 1'b1), plain_row(lgs_pkg::OP_FLUSH, 1'b1),
            plain_row(lgs_pkg::OP_FLUSH, 1'b1)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_side('0);
        foreach (directed_rows[i]) begin
            feed(directed_rows[i].opcode, directed_rows[i].cell_alive,
                 directed_rows[i].typed, directed_rows[i].want);
        end

        phase = 0;
        while (item_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            if (phase == 0) begin
                // Widest board: enough rows to see results, then abandoned by the next write.
                write_side(SIDE_REG_MAX);
                tx_idle_on  = 1'b0;
                rx_idle_on <= 1'b0;
                length = MAX_SIDE + $urandom_range(6, 30);
                for (int i = 0; i < length; i++) begin
                    feed(lgs_pkg::OP_CELL, 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end else if (phase == 1) begin
                write_side(lgs_pkg::CFG_W'(MAX_SIDE));
                tx_idle_on  = 1'b1;
                rx_idle_on <= 1'b1;
                length = $urandom_range(20, 40);
                for (int i = 0; i < length; i++) begin
                    feed(lgs_pkg::OP_CELL, 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    value = lgs_pkg::CFG_W'($urandom_range(0, lgs_pkg::MIN_SIDE - 1));
                end else if (pick < 60) begin
                    value = lgs_pkg::CFG_W'($urandom_range(3, 6));
                end else if (pick < 90) begin
                    value = lgs_pkg::CFG_W'($urandom_range(7, 12));
                end else begin
                    value = lgs_pkg::CFG_W'($urandom_range(13, 24));
                end
                write_side(value);
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_idle_on <= ($urandom_range(0, 3) != 0);
                if (phase == 2) begin
                    hold_request <= 1'b1;
                end
                s      = active_side();
                cells  = s * s;
                boards = $urandom_range(1, 3);
                for (int b = 0; b < boards; b++) begin
                    kind    = $urandom_range(0, 99);
                    density = $urandom_range(0, 100);
                    if (kind < 80) begin
                        length = cells + s + 1;
                    end else if (kind < 90) begin
                        length = $urandom_range(1, cells + s);
                    end else begin
                        length = $urandom_range(s, 2 * (cells + s + 1));
                    end
                    for (int i = 0; i < length; i++) begin
                        if (kind < 90) begin
                            op = (i < cells) ? lgs_pkg::OP_CELL : lgs_pkg::OP_FLUSH;
                        end else begin
                            op = ($urandom_range(0, 99) < 30) ? lgs_pkg::OP_FLUSH
                                                               : lgs_pkg::OP_CELL;
                        end
                        feed(op, 1'($urandom_range(0, 99) < density), 1'b0, '0);
                    end
                end
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && next_gen_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lgs_pkg.sv
rtl/lgs_if.sv
rtl/lgs_line_mem.sv
rtl/lgs_scan.sv
rtl/lgs_window.sv
rtl/life_generation_stencil_unit.sv
tb/testbench.sv
